[hw/rtl/fst_pkg.sv]
// Shared types and constants for the frame sequence timer.
// Depends on nothing; imported by frame_sequence_timer and its testbench.
package fst_pkg;

    localparam int TIME_W    = 20;
    localparam int LEFT_W    = 16;
    localparam int IDXOUT_W  = 4;
    localparam int DIV_STEPS = TIME_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_ADD     = 2'd1,
        OP_SET     = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_LOOK = 6'b001000,
        ST_WALK = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

endpackage

[hw/rtl/frame_sequence_timer.sv]
// Frame sequence timer: frame duration table, position keeping and frame lookup.
// Depends on fst_pkg (types, op codes, time constants).
//
// channel  direction  handshake                         payload
// s_axis   in         i_s_axis_tvalid/o_s_axis_tready   tuser: op; tdata: amount
// m_axis   out        o_m_axis_tvalid/i_m_axis_tready   tdata: index, left, time, flags
// cfg      in         i_cfg_we                          i_cfg_wdata: single_shot
//
// Each item runs exec, an optional divide, look and an optional walk, then done:
// a wrapped time runs a 21-step restoring modulo, the lookup walks the duration
// memory one frame per cycle; both share one adder. o_s_axis_tready is high only
// while idle. A result waits in the output register; a stalled output holds the
// next result in the final state. Reset is synchronous; the duration memory is not
// cleared, only entries below the frame count are ever read.
module frame_sequence_timer #(
    parameter int MAX_FRAMES    = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // amount[19:0], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // frame_index[3:0], frame_left[19:4],
                                          // current_time[39:20], finished[40],
                                          // has_frames[41], rejected[42], zero pad
);
    import fst_pkg::*;

    localparam int DW    = DURATION_BITS;
    localparam int AW    = (DW > TIME_W) ? DW : TIME_W;
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    // room for the sum of every stored duration plus a sign bit
    localparam int SW    = AW + IDX_W + 2;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam logic [DW-1:0] DMAX = {DW{1'b1}};

    t_state              r_state, n_state;
    logic                r_single_shot;
    logic [DW-1:0]       r_mem [MAX_FRAMES];
    logic [DW-1:0]       r_rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TIME_W-1:0]   r_total, n_total;
    logic [TIME_W-1:0]   r_pos, n_pos;
    logic                r_done, n_done;
    logic [1:0]          r_op;
    logic [TIME_W-1:0]   r_amount;
    logic [TIME_W:0]     r_dividend, n_dividend;
    logic [SW-1:0]       r_acc, n_acc;
    logic [DIV_CNT_W-1:0] r_bit, n_bit;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic [LEFT_W-1:0]   r_res_left, n_res_left;
    logic                r_rejected, n_rejected;
    logic                r_ovalid;
    logic [47:0]         r_odata;

    // shared adder
    logic [SW-1:0]       op_a, op_b, alu_sum;
    logic                op_cin;

    logic [AW-1:0]       amt_w;
    logic [DW-1:0]       dur_sat;
    logic                mem_we;
    logic [TIME_W:0]     div_p2;
    logic [TIME_W:0]     t_new;
    logic [IDX_W-1:0]    idx_inc;
    logic [IDX_W-1:0]    last_idx;
    logic                out_free;

    assign alu_sum  = op_a + op_b + SW'(op_cin);
    assign amt_w    = AW'(r_amount);
    assign dur_sat  = (amt_w > AW'(DMAX)) ? DMAX : DW'(amt_w);
    assign div_p2   = {r_acc[TIME_W-1:0], r_dividend[TIME_W]};
    assign t_new    = alu_sum[TIME_W:0];
    assign idx_inc  = r_idx + IDX_W'(1);
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign rd_addr  = (r_state == ST_WALK) ? idx_inc : '0;
    assign mem_we   = (r_state == ST_EXEC) && (t_op'(r_op) == OP_APPEND)
                      && (r_count < CNT_W'(MAX_FRAMES));

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        op_a = '0;
        op_b = '0;
        op_cin = 1'b0;
        unique case (r_state)
            ST_EXEC: begin
                if (t_op'(r_op) == OP_APPEND) begin
                    op_a = SW'(r_total);
                    op_b = SW'(dur_sat);
                end else begin
                    op_a = (t_op'(r_op) == OP_ADD) ? SW'(r_pos) : '0;
                    op_b = SW'(r_amount);
                end
            end
            ST_DIV: begin
                op_a = SW'(div_p2);
                op_b = ~SW'(r_total);
                op_cin = 1'b1;
            end
            ST_LOOK: begin
                // start from minus the lookup time
                op_b = (r_pos == r_total) ? ~SW'(0) : ~SW'(r_pos);
                op_cin = 1'b1;
            end
            ST_WALK: begin
                op_a = r_acc;
                op_b = SW'(r_rd_data);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_total    = r_total;
        n_pos      = r_pos;
        n_done     = r_done;
        n_dividend = r_dividend;
        n_acc      = r_acc;
        n_bit      = r_bit;
        n_idx      = r_idx;
        n_res_idx  = r_res_idx;
        n_res_left = r_res_left;
        n_rejected = r_rejected;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state    = ST_LOOK;
                n_rejected = 1'b0;
                unique case (t_op'(r_op))
                    OP_APPEND: begin
                        if (r_count >= CNT_W'(MAX_FRAMES)) begin
                            n_rejected = 1'b1;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_total = (alu_sum > SW'(TIME_MAX)) ? TIME_MAX
                                                                : alu_sum[TIME_W-1:0];
                            n_done  = 1'b0;
                        end
                    end
                    OP_ADD, OP_SET: begin
                        if (t_new > {1'b0, r_total}) begin
                            if (r_single_shot) begin
                                n_done = 1'b1;
                                n_pos  = r_total;
                            end else if (r_total == '0) begin
                                n_pos = '0;
                            end else begin
                                n_dividend = t_new;
                                n_acc      = '0;
                                n_bit      = '0;
                                n_state    = ST_DIV;
                            end
                        end else begin
                            n_pos = t_new[TIME_W-1:0];
                        end
                    end
                    OP_RESTART: begin
                        if (r_count != '0) begin
                            n_done = 1'b0;
                            n_pos  = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIV: begin
                // restoring step: keep the difference when it did not borrow
                n_acc      = alu_sum[SW-1] ? SW'(div_p2) : alu_sum;
                n_dividend = {r_dividend[TIME_W-1:0], 1'b0};
                n_bit      = r_bit + DIV_CNT_W'(1);
                if (r_bit == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_pos   = alu_sum[SW-1] ? div_p2[TIME_W-1:0] : alu_sum[TIME_W-1:0];
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_idx = '0;
                if (r_count == '0) begin
                    n_res_idx  = '0;
                    n_res_left = '0;
                    n_state    = ST_DONE;
                end else if (r_pos == r_total && (r_single_shot || r_total == '0)) begin
                    n_res_idx  = last_idx;
                    n_res_left = '0;
                    n_state    = ST_DONE;
                end else begin
                    n_acc   = alu_sum;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // acc holds cumulative duration minus time; first positive wins
                n_acc = alu_sum;
                n_idx = idx_inc;
                if (!alu_sum[SW-1] && alu_sum != '0) begin
                    n_res_idx  = r_idx;
                    n_res_left = (alu_sum > SW'(LEFT_MAX)) ? LEFT_MAX
                                                            : alu_sum[LEFT_W-1:0];
                    n_state    = ST_DONE;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_res_idx  = last_idx;
                    n_res_left = '0;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_single_shot <= 1'b0;
            r_count       <= '0;
            r_total       <= '0;
            r_pos         <= '0;
            r_done        <= 1'b1;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_single_shot <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_acc      <= n_acc;
        r_bit      <= n_bit;
        r_idx      <= n_idx;
        r_res_idx  <= n_res_idx;
        r_res_left <= n_res_left;
        r_rejected <= n_rejected;
        if (r_state == ST_IDLE && i_s_axis_tvalid) begin
            r_op     <= i_s_axis_tuser;
            r_amount <= i_s_axis_tdata[TIME_W-1:0];
        end
        if (r_state == ST_DONE && out_free) begin
            r_odata <= {5'b0, r_rejected, (r_count != '0), r_done, r_pos,
                        r_res_left, IDXOUT_W'(r_res_idx)};
        end
    end

    // duration memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= dur_sat;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

[tb/frame_sequence_timer_test.sv]
// Testbench for frame_sequence_timer: directed and random op streams, random stalls on
// both stream sides, every result checked field by field against a behavioral model.
// Depends on fst_pkg (op codes, time constants) and frame_sequence_timer.
module frame_sequence_timer_test;
    import fst_pkg::*;

    localparam int NFRAMES     = 16;
    localparam int DUR_MAX     = 65535;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 240;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] left;
        logic [19:0] tm;
        logic        fin;
        logic        has;
        logic        rej;
    } t_frame_report;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_wdata     = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;   // amount[19:0], zero pad
    logic [1:0]  i_s_axis_tuser  = '0;   // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;         // frame_index[3:0], frame_left[19:4],
                                         // current_time[39:20], finished[40],
                                         // has_frames[41], rejected[42], zero pad

    frame_sequence_timer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the frame table and play position
    logic [15:0] frame_len [NFRAMES];
    logic [4:0]  frames_stored = '0;
    logic [19:0] seq_total     = '0;
    logic [19:0] play_pos      = '0;
    logic        play_done     = 1'b1;
    logic        one_shot_mode = 1'b0;

    t_frame_report expected_reports [$];
    int  mismatches      = 0;
    int  reports_checked = 0;
    int  items_sent      = 0;
    int  op_count [4]    = '{0, 0, 0, 0};
    int  cycles          = 0;
    bit  tx_steady       = 1'b0;
    bit  rx_steady       = 1'b0;
    int  hold_req        = 0;
    int  hold_seen       = 0;
    int  hold_left       = 0;
    int  ready_wait      = 0;

    function automatic void place_position(logic [20:0] t);
        logic [20:0] w;
        w = t;
        if (t > {1'b0, seq_total}) begin
            if (one_shot_mode) begin
                play_done = 1'b1;
                play_pos  = seq_total;
                return;
            end
            w = (seq_total == 0) ? '0 : t % seq_total;
        end
        play_pos = w[19:0];
    endfunction

    function automatic t_frame_report advance_sequence(t_op op, logic [19:0] amount);
        t_frame_report r;
        logic [20:0]   t;
        logic [20:0]   cum;
        logic [20:0]   span;
        logic [4:0]    last;
        bit            hit;
        r = '0;
        case (op)
            OP_APPEND: begin
                if (frames_stored >= NFRAMES) begin
                    r.rej = 1'b1;
                end else begin
                    frame_len[frames_stored[3:0]] = (amount > DUR_MAX) ? 16'hFFFF
                                                                       : amount[15:0];
                    cum = {1'b0, seq_total} + frame_len[frames_stored[3:0]];
                    seq_total = (cum > TIME_MAX) ? TIME_MAX : cum[19:0];
                    frames_stored = frames_stored + 5'd1;
                    play_done = 1'b0;
                end
            end
            OP_ADD: place_position({1'b0, play_pos} + amount);
            OP_SET: place_position({1'b0, amount});
            default: begin
                if (frames_stored != 0) begin
                    play_done = 1'b0;
                    play_pos  = '0;
                end
            end
        endcase

        // walk cumulative durations to the frame under the play position
        if (frames_stored != 0) begin
            last = frames_stored - 5'd1;
            t    = {1'b0, play_pos};
            hit  = 1'b0;
            if (t >= seq_total && (one_shot_mode || seq_total == 0)) begin
                r.idx = last[3:0];
                hit   = 1'b1;
            end else if (t >= seq_total) begin
                t = t % seq_total;
            end
            cum = '0;
            for (int i = 0; i < NFRAMES; i++) begin
                if (!hit && i < frames_stored) begin
                    cum = cum + frame_len[i];
                    if (cum > t) begin
                        span   = cum - t;
                        r.idx  = i[3:0];
                        r.left = (span > LEFT_MAX) ? LEFT_MAX : span[15:0];
                        hit    = 1'b1;
                    end
                end
            end
            if (!hit) r.idx = last[3:0];
        end
        r.tm  = play_pos;
        r.fin = play_done;
        r.has = (frames_stored != 0);
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_frame_report want;
        t_frame_report got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.idx  = o_m_axis_tdata[3:0];
            got.left = o_m_axis_tdata[19:4];
            got.tm   = o_m_axis_tdata[39:20];
            got.fin  = o_m_axis_tdata[40];
            got.has  = o_m_axis_tdata[41];
            got.rej  = o_m_axis_tdata[42];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item: tdata %h", o_m_axis_tdata);
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result %0d: expected idx %0d left %0d time %0d fin %b has %b rej %b",
                                 reports_checked, want.idx, want.left, want.tm, want.fin,
                                 want.has, want.rej);
                        $display("    got idx %0d left %0d time %0d fin %b has %b rej %b",
                                 got.idx, got.left, got.tm, got.fin, got.has, got.rej);
                    end
                end
                reports_checked++;
            end
        end
    end

    // receiver: random wait per item, plus a long hold-off on request
    always @(posedge i_clk) begin : drive_ready
        int w;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            ready_wait      <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (ready_wait != 0) begin
            ready_wait      <= ready_wait - 1;
            i_m_axis_tready <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            w = rx_steady ? 0 : $urandom_range(0, 8);
            if (w == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                ready_wait      <= w - 1;
            end
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_reports.size());
            $display("frame_sequence_timer_test: done, errors");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [19:0] amount);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, amount};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_reports.insert(expected_reports.size(), advance_sequence(op, amount));
        items_sent++;
        op_count[op]++;
    endtask

    task automatic wait_reports();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
    endtask

    task automatic set_playback(bit shot);
        wait_reports();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= shot;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        one_shot_mode = shot;
    endtask

    // no frames yet: time ops report frame 0, restart is ignored
    task automatic test_empty_table();
        send_item(OP_ADD, 20'd5);
        send_item(OP_SET, 20'hFFFFF);
        send_item(OP_RESTART, 20'd0);
        set_playback(1'b1);
        send_item(OP_SET, 20'd7);
        send_item(OP_ADD, 20'd0);
    endtask

    // a frame of zero length: looping keeps time 0, single-shot clamps and finishes
    task automatic test_zero_total();
        set_playback(1'b0);
        send_item(OP_APPEND, 20'd0);
        send_item(OP_SET, 20'd9);
        send_item(OP_ADD, 20'd3);
        set_playback(1'b1);
        send_item(OP_SET, 20'd1);
        send_item(OP_RESTART, 20'd0);
    endtask

    // saturating durations, then times at, just past and far past the end
    task automatic test_wide_duration();
        send_item(OP_APPEND, 20'hFFFFF);
        send_item(OP_APPEND, 20'h10000);
        send_item(OP_APPEND, 20'd5);
        send_item(OP_SET, seq_total);
        send_item(OP_SET, seq_total + 20'd1);
        send_item(OP_ADD, 20'd1);
        set_playback(1'b0);
        send_item(OP_SET, seq_total);
        send_item(OP_ADD, seq_total + 20'd1);
        send_item(OP_RESTART, 20'd0);
    endtask

    // fill the table with mixed durations, probing the walk as it grows, then overflow it
    task automatic test_fill_table();
        logic [19:0] dur;
        while (frames_stored < NFRAMES) begin
            dur = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
            send_item(OP_APPEND, dur);
            send_item(OP_ADD, 20'($urandom_range(0, 2000)));
        end
        repeat (3) send_item(OP_APPEND, 20'($urandom));
    endtask

    task automatic test_random_play();
        int unsigned tot;
        int          sel;
        int          pick;
        logic [19:0] amt;
        for (int p = 0; p < PHASES; p++) begin
            set_playback(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
            tx_steady = (p == 2);
            rx_steady <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                tot  = seq_total;
                sel  = $urandom_range(0, 99);
                pick = $urandom_range(0, 9);
                if (sel < 5) begin
                    send_item(OP_APPEND, 20'($urandom));
                end else if (sel < 45) begin
                    if (pick < 6)
                        amt = 20'($urandom_range(0, tot / 8 + 1));
                    else if (pick < 8)
                        amt = 20'($urandom_range(0, tot + 16));
                    else
                        amt = 20'($urandom);
                    send_item(OP_ADD, amt);
                end else if (sel < 85) begin
                    if (pick < 4)
                        amt = 20'($urandom_range(0, tot));
                    else if (pick < 6)
                        amt = 20'($urandom_range(tot > 2 ? tot - 2 : 0, tot + 2));
                    else if (pick < 8)
                        amt = 20'($urandom_range(tot, 2 * tot + 3));
                    else
                        amt = 20'($urandom);
                    send_item(OP_SET, amt);
                end else begin
                    send_item(OP_RESTART, 20'($urandom));
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // hold the receiver off while items keep coming, pause until all results are in, then send set ops
    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_req <= hold_req + 1;
        repeat (10) send_item(OP_ADD, 20'($urandom_range(0, 4000)));
        wait_reports();
        tx_steady = 1'b0;
        repeat (10) send_item(OP_SET, 20'($urandom_range(0, seq_total)));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_zero_total();
        test_wide_duration();
        test_fill_table();
        test_random_play();
        test_backpressure();

        wait_reports();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d items (append %0d, add %0d, set %0d, restart %0d), both modes",
                 items_sent, op_count[OP_APPEND], op_count[OP_ADD], op_count[OP_SET],
                 op_count[OP_RESTART]);
        $display("%0d results checked, %0d mismatches, output hold-off and drain exercised",
                 reports_checked, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("frame_sequence_timer_test: done, clean");
        end else begin
            $display("frame_sequence_timer_test: done, errors");
        end
        $finish;
    end

endmodule
